/* rtl/particle_plane_collision_assert.svh */
// Assertion macros shared by the particle plane collision RTL.
`ifndef PARTICLE_PLANE_COLLISION_ASSERT_SVH
`define PARTICLE_PLANE_COLLISION_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define PPC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("particle_plane_collision: check failed");
// Check that a condition implies another in the same cycle.
`define PPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("particle_plane_collision: implication failed");
`else
`define PPC_ASSERT(lbl, expr)
`define PPC_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

/* rtl/ppc_pkg.sv */
// Types and constants of the particle plane collision block.
`default_nettype none

package ppc_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } particle_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] force_add_x;
    logic signed [31:0] force_add_y;
    logic signed [31:0] force_add_z;
  } response_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_X        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_Y        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESTITUTION     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRICTION        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTACT_EPSILON = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_EXTENT     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_TIME_STEP   = 3'd6;

  localparam logic signed [15:0] NORMAL_X_RST        = 16'sd5604;
  localparam logic signed [15:0] NORMAL_Y_RST        = 16'sd15396;
  localparam logic [16:0]        RESTITUTION_RST     = 17'd52429;
  localparam logic [16:0]        FRICTION_RST        = 17'd32768;
  localparam logic [16:0]        CONTACT_EPSILON_RST = 17'd655;
  localparam logic [30:0]        HALF_EXTENT_RST     = 31'd983040;
  localparam logic [30:0]        INV_TIME_STEP_RST   = 31'd65536;

  // One in Q1.16.
  localparam logic [16:0] ONE_Q16 = 17'd65536;

endpackage

`default_nettype wire

/* rtl/particle_plane_collision.sv */
// Particle versus tilted square plane collision response, eight-stage pipeline.
// A transaction is accepted when start is high and busy low, and its result shows with
//   done high at the pipeline end; throughput is one transaction every cycle while busy is low.
// Multiplier stages set the depth: dot products, normal projection, scaling, force.
// Reset (rst, synchronous) clears every stage valid, loads register defaults
//   and holds busy high until the cycle after reset; the receiver cannot stall.
`default_nettype none
`include "particle_plane_collision_assert.svh"

module particle_plane_collision
  import ppc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire particle_t              particle,
  output logic                        done,
  output response_t                   response,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vel_t;

  // Force scale clamp: 2^46 in Q16.16.
  localparam logic [49:0] S_MAX = 50'd1 << 46;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers; the user must write them only while the pipeline is empty, the block does not check.
  // ---------------------------------------------------------------------------
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic [16:0]        restitution;
  logic [16:0]        friction;
  logic [16:0]        contact_epsilon;
  logic [30:0]        half_extent;
  logic [30:0]        inv_time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x        <= NORMAL_X_RST;
      normal_y        <= NORMAL_Y_RST;
      restitution     <= RESTITUTION_RST;
      friction        <= FRICTION_RST;
      contact_epsilon <= CONTACT_EPSILON_RST;
      half_extent     <= HALF_EXTENT_RST;
      inv_time_step   <= INV_TIME_STEP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NORMAL_X:        normal_x        <= cfg_data[15:0];
        REG_NORMAL_Y:        normal_y        <= cfg_data[15:0];
        REG_RESTITUTION:     restitution     <= cfg_data[16:0];
        REG_FRICTION:        friction        <= cfg_data[16:0];
        REG_CONTACT_EPSILON: contact_epsilon <= cfg_data[16:0];
        REG_HALF_EXTENT:     half_extent     <= cfg_data[30:0];
        REG_INV_TIME_STEP:   inv_time_step   <= cfg_data[30:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and valid chain. Every stage advances each cycle; nothing stalls.
  // ---------------------------------------------------------------------------
  logic       accept;
  logic [6:0] stage_valid;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      stage_valid <= '0;
      done        <= 1'b0;
    end else begin
      busy        <= 1'b0;
      stage_valid <= {stage_valid[5:0], accept};
      done        <= stage_valid[6];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: square bounds test and the four dot-product terms.
  // ---------------------------------------------------------------------------
  logic [32:0]        abs_x;
  logic [32:0]        abs_z;
  logic               in_square;
  logic               s1_inside;
  logic signed [47:0] s1_pxn, s1_pyn, s1_vxn, s1_vyn;
  vel_t               s1_vel;

  assign abs_x  = particle.pos_x[31] ? (33'd0 - {1'b1, particle.pos_x})
                                     : {1'b0, particle.pos_x};
  assign abs_z  = particle.pos_z[31] ? (33'd0 - {1'b1, particle.pos_z})
                                     : {1'b0, particle.pos_z};
  // The edge of the square still counts as inside.
  assign in_square = (abs_x <= {2'b00, half_extent}) && (abs_z <= {2'b00, half_extent});

  always_ff @(posedge clk) begin
    s1_inside <= in_square;
    s1_pxn    <= particle.pos_x * normal_x;
    s1_pyn    <= particle.pos_y * normal_y;
    s1_vxn    <= particle.vel_x * normal_x;
    s1_vyn    <= particle.vel_y * normal_y;
    s1_vel    <= '{x: particle.vel_x, y: particle.vel_y, z: particle.vel_z};
  end

  // ---------------------------------------------------------------------------
  // Stage 2: signed distance d and normal speed v.n, both exact in Q.30.
  // ---------------------------------------------------------------------------
  logic signed [48:0] s2_d30, s2_vd30;
  logic               s2_inside;
  vel_t               s2_vel;

  always_ff @(posedge clk) begin
    s2_d30    <= 49'(s1_pxn) + 49'(s1_pyn);
    s2_vd30   <= 49'(s1_vxn) + 49'(s1_vyn);
    s2_inside <= s1_inside;
    s2_vel    <= s1_vel;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: contact decision, normal projection products, penetration.
  // ---------------------------------------------------------------------------
  logic signed [48:0] eps30;
  logic               s3_hit, s3_neg;
  logic signed [64:0] s3_vnp_x, s3_vnp_y;
  logic signed [49:0] s3_pen;
  vel_t               s3_vel;

  assign eps30 = $signed({18'd0, contact_epsilon, 14'd0});

  always_ff @(posedge clk) begin
    s3_hit   <= s2_inside && (s2_d30 < eps30);
    s3_neg   <= s2_vd30[48];  // approaching: v.n below zero
    s3_vnp_x <= s2_vd30 * normal_x;
    s3_vnp_y <= s2_vd30 * normal_y;
    s3_pen   <= 50'(eps30) - 50'(s2_d30);
    s3_vel   <= s2_vel;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: round the normal velocity to Q16.16, split off the tangential
  // part, round the penetration to Q16.16.
  // ---------------------------------------------------------------------------
  logic signed [65:0] r28_x, r28_y;
  logic signed [37:0] vn_x, vn_y;
  logic signed [50:0] r14_pen;
  logic signed [37:0] s4_vn_x, s4_vn_y;
  logic signed [38:0] s4_t_x, s4_t_y;
  logic [34:0]        s4_pen;
  logic               s4_hit, s4_neg;
  vel_t               s4_vel;

  assign r28_x   = 66'(s3_vnp_x) + 66'sd134217728;
  assign r28_y   = 66'(s3_vnp_y) + 66'sd134217728;
  assign vn_x    = r28_x[65:28];
  assign vn_y    = r28_y[65:28];
  assign r14_pen = 51'(s3_pen) + 51'sd8192;

  always_ff @(posedge clk) begin
    s4_vn_x <= vn_x;
    s4_vn_y <= vn_y;
    s4_t_x  <= 39'(s3_vel.x) - 39'(vn_x);
    s4_t_y  <= 39'(s3_vel.y) - 39'(vn_y);
    // Penetration is positive on a hit; its value is unused otherwise.
    s4_pen  <= r14_pen[48:14];
    s4_hit  <= s3_hit;
    s4_neg  <= s3_neg;
    s4_vel  <= s3_vel;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: restitution, friction and inverse time step products.
  // ---------------------------------------------------------------------------
  logic [16:0]        keep;
  logic signed [17:0] keep_s, rest_s;
  logic signed [55:0] s5_rv_x, s5_rv_y;
  logic signed [56:0] s5_kt_x, s5_kt_y;
  logic signed [49:0] s5_kt_z;
  logic [65:0]        s5_ps;
  logic signed [37:0] s5_vn_x, s5_vn_y;
  logic               s5_hit, s5_neg;
  vel_t               s5_vel;

  // Friction above one acts as one.
  assign keep   = (friction > ONE_Q16) ? 17'd0 : ONE_Q16 - friction;
  assign keep_s = $signed({1'b0, keep});
  assign rest_s = $signed({1'b0, restitution});

  always_ff @(posedge clk) begin
    s5_rv_x <= s4_vn_x * rest_s;
    s5_rv_y <= s4_vn_y * rest_s;
    s5_kt_x <= s4_t_x * keep_s;
    s5_kt_y <= s4_t_y * keep_s;
    s5_kt_z <= s4_vel.z * keep_s;
    s5_ps   <= s4_pen * inv_time_step;
    s5_vn_x <= s4_vn_x;
    s5_vn_y <= s4_vn_y;
    s5_hit  <= s4_hit;
    s5_neg  <= s4_neg;
    s5_vel  <= s4_vel;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: round the scaled parts, reflect the normal part when approaching,
  // floor and clamp the force scale.
  // ---------------------------------------------------------------------------
  logic signed [56:0] r16_rv_x, r16_rv_y;
  logic signed [57:0] r16_kt_x, r16_kt_y;
  logic signed [50:0] r16_kt_z;
  logic signed [40:0] rv_x, rv_y;
  logic [49:0]        ps_hi;
  logic signed [41:0] s6_vn_x, s6_vn_y;
  logic signed [41:0] s6_t_x, s6_t_y;
  logic signed [34:0] s6_t_z;
  logic [46:0]        s6_s;
  logic               s6_hit;
  vel_t               s6_vel;

  assign r16_rv_x = 57'(s5_rv_x) + 57'sd32768;
  assign r16_rv_y = 57'(s5_rv_y) + 57'sd32768;
  assign r16_kt_x = 58'(s5_kt_x) + 58'sd32768;
  assign r16_kt_y = 58'(s5_kt_y) + 58'sd32768;
  assign r16_kt_z = 51'(s5_kt_z) + 51'sd32768;
  assign rv_x     = r16_rv_x[56:16];
  assign rv_y     = r16_rv_y[56:16];
  assign ps_hi    = s5_ps[65:16];

  always_ff @(posedge clk) begin
    s6_vn_x <= s5_neg ? -42'(rv_x) : 42'(s5_vn_x);
    s6_vn_y <= s5_neg ? -42'(rv_y) : 42'(s5_vn_y);
    s6_t_x  <= r16_kt_x[57:16];
    s6_t_y  <= r16_kt_y[57:16];
    s6_t_z  <= r16_kt_z[50:16];
    s6_s    <= (ps_hi > S_MAX) ? S_MAX[46:0] : ps_hi[46:0];
    s6_hit  <= s5_hit;
    s6_vel  <= s5_vel;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: recombine and saturate the velocity; force products along n.
  // ---------------------------------------------------------------------------
  logic signed [47:0] s_signed;
  logic signed [31:0] s7_nv_x, s7_nv_y, s7_nv_z;
  logic signed [63:0] s7_f_x, s7_f_y;
  logic               s7_hit;
  vel_t               s7_vel;

  assign s_signed = $signed({1'b0, s6_s});

  always_ff @(posedge clk) begin
    s7_nv_x <= sat32(64'(s6_vn_x) + 64'(s6_t_x));
    s7_nv_y <= sat32(64'(s6_vn_y) + 64'(s6_t_y));
    s7_nv_z <= sat32(64'(s6_t_z));
    s7_f_x  <= s_signed * normal_x;
    s7_f_y  <= s_signed * normal_y;
    s7_hit  <= s6_hit;
    s7_vel  <= s6_vel;
  end

  // ---------------------------------------------------------------------------
  // Stage 8: round and saturate the force, select hit or pass-through, and
  // hold the transaction on the output register for one cycle.
  // ---------------------------------------------------------------------------
  logic signed [64:0] r14_f_x, r14_f_y;
  logic signed [50:0] f_x, f_y;

  assign r14_f_x = 65'(s7_f_x) + 65'sd8192;
  assign r14_f_y = 65'(s7_f_y) + 65'sd8192;
  assign f_x     = r14_f_x[64:14];
  assign f_y     = r14_f_y[64:14];

  always_ff @(posedge clk) begin
    response.hit         <= s7_hit;
    response.new_vel_x   <= s7_hit ? s7_nv_x : s7_vel.x;
    response.new_vel_y   <= s7_hit ? s7_nv_y : s7_vel.y;
    response.new_vel_z   <= s7_hit ? s7_nv_z : s7_vel.z;
    response.force_add_x <= s7_hit ? sat32(64'(f_x)) : 32'sd0;
    response.force_add_y <= s7_hit ? sat32(64'(f_y)) : 32'sd0;
    // The normal has no z part, so neither has the force.
    response.force_add_z <= 32'sd0;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PPC_ASSERT(a_done_latency, done == $past(start && !busy, 8))
  `PPC_ASSERT_IMP(a_miss_no_force, done && !response.hit, response.force_add_x == 0 && response.force_add_y == 0)
  `PPC_ASSERT_IMP(a_force_z_zero, done, response.force_add_z == 0)
  `PPC_ASSERT_IMP(a_busy_after_reset, busy, $past(rst))

endmodule

`default_nettype wire
